### rtl/nsss_pkg.sv
// shared widths, codes, types and constant tables of the nsss sequence generator
`default_nettype none

package nsss_pkg;

   // field widths
   localparam int IDX_W      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int GRID_W     = 4;
   localparam int CELL_W     = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam int FRAC_BITS_DEF = 14;

   // sequence geometry
   localparam int SEQ_LEN   = 132;
   localparam int ZC_LEN    = 131;
   localparam int GRID_ROWS = 12;

   // internal widths
   localparam int ROOT_W  = 8;
   localparam int MASK_W  = 7;
   localparam int SHIFT_W = 5;
   localparam int ZC_W    = 9;
   localparam int PROD_W  = 16;
   localparam int QUOT_W  = 7;
   localparam int PHASE_W = 11;
   localparam int ANG_W   = 9;

   // phase arithmetic
   localparam int ZC_MOD      = 262;
   localparam int FULL_TURN   = 1048;
   localparam int QUARTER     = 262;
   localparam int RECIP_SHIFT = 24;
   localparam logic [PROD_W-1:0] RECIP_ZC = PROD_W'((1 << RECIP_SHIFT) / ZC_MOD);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME   = 1'b1;

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [ROOT_W-1:0]  root;
      logic [MASK_W-1:0]  mask;
      logic [SHIFT_W-1:0] shift;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        quad;
      logic [ANG_W-1:0]  ang;
      logic              neg;
      logic [GRID_W-1:0] row;
      logic [GRID_W-1:0] col;
   } phase_type;

   typedef logic [ZC_W-1:0]       zc_tbl_type   [SEQ_LEN];
   typedef logic [2*GRID_W-1:0]   grid_tbl_type [SEQ_LEN];
   typedef logic [2*SAMPLE_W-1:0] trig_rom_type [QUARTER];

   // n'(n'+1) mod 262 with n' = n mod 131
   function automatic zc_tbl_type zc_tbl_build();
      zc_tbl_type t;
      int np;
      for (int n = 0; n < SEQ_LEN; n++) begin
         np   = n % ZC_LEN;
         t[n] = ZC_W'((np * (np + 1)) % ZC_MOD);
      end
      return t;
   endfunction

   // {column, row} of the column-major grid
   function automatic grid_tbl_type grid_tbl_build();
      grid_tbl_type t;
      for (int n = 0; n < SEQ_LEN; n++) begin
         t[n] = {GRID_W'(n / GRID_ROWS), GRID_W'(n % GRID_ROWS)};
      end
      return t;
   endfunction

   localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
   localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
   localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd524;
   localparam logic [63:0] REM_Q62  = PI_Q62 % 64'd524;

   // (a*b) >> 62, truncated
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // {sin, cos} of r*pi/524, taylor series in q2.62, rounded magnitude low bits
   function automatic logic [2*SAMPLE_W-1:0] sincos_entry(int r, int frac);
      logic [63:0] x, x2, ts, tc, ss, cc, sr, cr;
      x  = 64'(r) * STEP_Q62 + (64'(r) * REM_Q62) / 64'd524;
      x2 = qmul(x, x);
      ts = x;
      tc = ONE_Q62;
      ss = x;
      cc = ONE_Q62;
      ts = qmul(ts, x2) / 64'd6;   tc = qmul(tc, x2) / 64'd2;   ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd20;  tc = qmul(tc, x2) / 64'd12;  ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd42;  tc = qmul(tc, x2) / 64'd30;  ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd72;  tc = qmul(tc, x2) / 64'd56;  ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd110; tc = qmul(tc, x2) / 64'd90;  ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd156; tc = qmul(tc, x2) / 64'd132; ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd210; tc = qmul(tc, x2) / 64'd182; ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd272; tc = qmul(tc, x2) / 64'd240; ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd342; tc = qmul(tc, x2) / 64'd306; ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd420; tc = qmul(tc, x2) / 64'd380; ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd506; tc = qmul(tc, x2) / 64'd462; ss = ss - ts; cc = cc - tc;
      ts = qmul(ts, x2) / 64'd600; tc = qmul(tc, x2) / 64'd552; ss = ss + ts; cc = cc + tc;
      ts = qmul(ts, x2) / 64'd702; tc = qmul(tc, x2) / 64'd650; ss = ss - ts; cc = cc - tc;
      sr = (ss + (64'd1 << (61 - frac))) >> (62 - frac);
      cr = (cc + (64'd1 << (61 - frac))) >> (62 - frac);
      return {sr[SAMPLE_W-1:0], cr[SAMPLE_W-1:0]};
   endfunction

   function automatic trig_rom_type trig_rom_build(int frac);
      trig_rom_type t;
      for (int r = 0; r < QUARTER; r++) begin
         t[r] = sincos_entry(r, frac);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

### rtl/nsss_if.sv
// handshake channels of the nsss sequence generator: request, response, register write
`default_nettype none

interface nsss_req_if;
   import nsss_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] sample_index;
   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

interface nsss_rsp_if;
   import nsss_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_i;
   logic signed [SAMPLE_W-1:0] sample_q;
   logic [GRID_W-1:0]          grid_row;
   logic [GRID_W-1:0]          grid_col;
   modport source (output valid, output sample_i, output sample_q, output grid_row,
                   output grid_col, input ready);
   modport sink   (input valid, input sample_i, input sample_q, input grid_row,
                   input grid_col, output ready);
endinterface

interface nsss_csr_if;
   import nsss_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/nsss_csr.sv
// register file: cell id split into root and sign mask, frame number into cyclic shift
`default_nettype none

module nsss_csr (
   input  wire               clock,
   input  wire               reset,
   nsss_csr_if.sink          csr,
   output nsss_pkg::cfg_type cfg
);
   import nsss_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic [CELL_W-1:0] cell_id;
   logic [CELL_W-1:0] cell_mod;
   logic [MASK_W-1:0] mask;

   assign csr.ready = 1'b1;
   assign cell_id   = csr.data[CELL_W-1:0];

   // cell mod 126 and sign row, row saturated at the last one
   always_comb begin
      if (cell_id >= CELL_W'(504)) begin
         cell_mod = cell_id - CELL_W'(504);
         mask     = 7'h7F;
      end else if (cell_id >= CELL_W'(378)) begin
         cell_mod = cell_id - CELL_W'(378);
         mask     = 7'h7F;
      end else if (cell_id >= CELL_W'(252)) begin
         cell_mod = cell_id - CELL_W'(252);
         mask     = 7'h3F;
      end else if (cell_id >= CELL_W'(126)) begin
         cell_mod = cell_id - CELL_W'(126);
         mask     = 7'h1F;
      end else begin
         cell_mod = cell_id;
         mask     = 7'h00;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr.index)
         CSR_CELL_ID: begin
            cfg_in.root = ROOT_W'(cell_mod) + ROOT_W'(3);
            cfg_in.mask = mask;
         end
         CSR_FRAME: begin
            cfg_in.shift = csr.data[SHIFT_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root  <= ROOT_W'(3);
         cfg_ff.mask  <= '0;
         cfg_ff.shift <= '0;
      end else if (csr.valid && csr.ready) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/nsss_phase.sv
// phase pipeline: index reduction, zadoff-chu phase mod 1048, quadrant split, sign and grid
`default_nettype none

module nsss_phase (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 adv,
   input  nsss_pkg::cfg_type   cfg,
   nsss_req_if.sink            req,
   output nsss_pkg::phase_type ph
);
   import nsss_pkg::*;

   localparam zc_tbl_type   ZC_TBL   = zc_tbl_build();
   localparam grid_tbl_type GRID_TBL = grid_tbl_build();

   // valid bits of stages one to six
   logic [5:0] v_ff, v_in;

   // stage 1
   logic [IDX_W-1:0] n1_ff, n1_in;
   // stage 2
   logic [ZC_W-1:0]     a2_ff;
   logic [2*GRID_W-1:0] grid2_ff;
   logic                neg2_ff;
   logic [2:0]          s2_ff;
   logic [5:0]          sprod;
   // stage 3
   logic [PROD_W-1:0]   b3_ff;
   logic [2*GRID_W-1:0] grid3_ff;
   logic                neg3_ff;
   logic [2:0]          s3_ff;
   logic [PROD_W:0]     bprod;
   // stage 4
   logic [PROD_W-1:0]   b4_ff;
   logic [QUOT_W-1:0]   q4_ff;
   logic [2*GRID_W-1:0] grid4_ff;
   logic                neg4_ff;
   logic [2:0]          s4_ff;
   logic [2*PROD_W-1:0] qprod;
   // stage 5
   logic [ANG_W-1:0]    rem5_ff, rem5_in;
   logic [2*GRID_W-1:0] grid5_ff;
   logic                neg5_ff;
   logic [2:0]          s5_ff;
   logic [PROD_W-1:0]   qmul262, diff;
   // stage 6
   logic [PHASE_W-1:0]  k6_ff, k6_in;
   logic [2*GRID_W-1:0] grid6_ff;
   logic                neg6_ff;
   logic [PHASE_W:0]    psum;
   logic [PHASE_W-1:0]  pred;
   // stage 7
   phase_type           ph_ff, ph_in;

   assign req.ready = adv;

   always_comb begin
      if (req.sample_index >= IDX_W'(SEQ_LEN)) begin
         n1_in = req.sample_index - IDX_W'(SEQ_LEN);
      end else begin
         n1_in = req.sample_index;
      end
   end

   // only n*f mod 8 matters since 131*x mod 1048 = 131*(x mod 8)
   assign sprod = {3'd0, n1_ff[2:0]} * {3'd0, cfg.shift[2:0]};
   assign bprod = {1'b0, {(PROD_W-ROOT_W){1'b0}}, cfg.root} *
                  {1'b0, {(PROD_W-ZC_W){1'b0}}, a2_ff};
   assign qprod = {{PROD_W{1'b0}}, b3_ff} * {{PROD_W{1'b0}}, RECIP_ZC};

   // reciprocal quotient is low by at most one
   assign qmul262 = {{(PROD_W-QUOT_W){1'b0}}, q4_ff} * PROD_W'(ZC_MOD);
   assign diff    = b4_ff - qmul262;

   always_comb begin
      if (diff >= PROD_W'(ZC_MOD)) begin
         rem5_in = ANG_W'(diff - PROD_W'(ZC_MOD));
      end else begin
         rem5_in = ANG_W'(diff);
      end
   end

   // phase 4*r + 131*s mod 1048, then negated
   always_comb begin
      psum = {1'b0, rem5_ff, 2'b00} + {{(PHASE_W-2){1'b0}}, s5_ff} * (PHASE_W+1)'(ZC_LEN);
      if (psum >= (PHASE_W+1)'(FULL_TURN)) begin
         pred = PHASE_W'(psum - (PHASE_W+1)'(FULL_TURN));
      end else begin
         pred = PHASE_W'(psum);
      end
      if (pred == '0) begin
         k6_in = '0;
      end else begin
         k6_in = PHASE_W'(FULL_TURN) - pred;
      end
   end

   always_comb begin
      ph_in.valid = v_ff[5];
      ph_in.neg   = neg6_ff;
      ph_in.col   = grid6_ff[2*GRID_W-1:GRID_W];
      ph_in.row   = grid6_ff[GRID_W-1:0];
      if (k6_ff >= PHASE_W'(3 * QUARTER)) begin
         ph_in.quad = QUAD_3;
         ph_in.ang  = ANG_W'(k6_ff - PHASE_W'(3 * QUARTER));
      end else if (k6_ff >= PHASE_W'(2 * QUARTER)) begin
         ph_in.quad = QUAD_2;
         ph_in.ang  = ANG_W'(k6_ff - PHASE_W'(2 * QUARTER));
      end else if (k6_ff >= PHASE_W'(QUARTER)) begin
         ph_in.quad = QUAD_1;
         ph_in.ang  = ANG_W'(k6_ff - PHASE_W'(QUARTER));
      end else begin
         ph_in.quad = QUAD_0;
         ph_in.ang  = ANG_W'(k6_ff);
      end
   end

   assign v_in = {v_ff[4:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= '0;
         ph_ff.valid <= 1'b0;
      end else if (adv) begin
         v_ff        <= v_in;
         ph_ff.valid <= ph_in.valid;
      end
      if (adv) begin
         n1_ff    <= n1_in;
         a2_ff    <= ZC_TBL[n1_ff];
         grid2_ff <= GRID_TBL[n1_ff];
         neg2_ff  <= ^(n1_ff[MASK_W-1:0] & cfg.mask);
         s2_ff    <= sprod[2:0];
         b3_ff    <= bprod[PROD_W-1:0];
         grid3_ff <= grid2_ff;
         neg3_ff  <= neg2_ff;
         s3_ff    <= s2_ff;
         b4_ff    <= b3_ff;
         q4_ff    <= qprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
         grid4_ff <= grid3_ff;
         neg4_ff  <= neg3_ff;
         s4_ff    <= s3_ff;
         rem5_ff  <= rem5_in;
         grid5_ff <= grid4_ff;
         neg5_ff  <= neg4_ff;
         s5_ff    <= s4_ff;
         k6_ff    <= k6_in;
         grid6_ff <= grid5_ff;
         neg6_ff  <= neg5_ff;
         ph_ff.quad <= ph_in.quad;
         ph_ff.ang  <= ph_in.ang;
         ph_ff.neg  <= ph_in.neg;
         ph_ff.row  <= ph_in.row;
         ph_ff.col  <= ph_in.col;
      end
   end

   assign ph = ph_ff;

endmodule

`default_nettype wire

### rtl/nsss_trig.sv
// quarter-wave sine/cosine rom, quadrant folding, sign and output register
`default_nettype none

module nsss_trig #(
   parameter int FRAC_BITS = nsss_pkg::FRAC_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  nsss_pkg::phase_type ph,
   output logic                adv,
   nsss_rsp_if.source          rsp
);
   import nsss_pkg::*;

   localparam trig_rom_type TRIG_ROM = trig_rom_build(FRAC_BITS);

   logic [2*SAMPLE_W-1:0] rom_ff;
   phase_type             ph8_ff;
   logic                  v9_ff;
   logic [SAMPLE_W-1:0]   i9_ff, i9_in, q9_ff, q9_in;
   logic [GRID_W-1:0]     row9_ff, col9_ff;
   logic [SAMPLE_W-1:0]   sin_mag, cos_mag, i_mag, q_mag;
   logic                  i_neg, q_neg;

   assign adv = !v9_ff || rsp.ready;

   assign sin_mag = rom_ff[2*SAMPLE_W-1:SAMPLE_W];
   assign cos_mag = rom_ff[SAMPLE_W-1:0];

   always_comb begin
      unique case (ph8_ff.quad)
         QUAD_0: begin
            i_mag = cos_mag; i_neg = 1'b0; q_mag = sin_mag; q_neg = 1'b0;
         end
         QUAD_1: begin
            i_mag = sin_mag; i_neg = 1'b1; q_mag = cos_mag; q_neg = 1'b0;
         end
         QUAD_2: begin
            i_mag = cos_mag; i_neg = 1'b1; q_mag = sin_mag; q_neg = 1'b1;
         end
         QUAD_3: begin
            i_mag = sin_mag; i_neg = 1'b0; q_mag = cos_mag; q_neg = 1'b1;
         end
      endcase
      i9_in = (i_neg ^ ph8_ff.neg) ? (~i_mag + SAMPLE_W'(1)) : i_mag;
      q9_in = (q_neg ^ ph8_ff.neg) ? (~q_mag + SAMPLE_W'(1)) : q_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph8_ff.valid <= 1'b0;
         v9_ff        <= 1'b0;
      end else if (adv) begin
         ph8_ff.valid <= ph.valid;
         v9_ff        <= ph8_ff.valid;
      end
      if (adv) begin
         rom_ff      <= TRIG_ROM[ph.ang];
         ph8_ff.quad <= ph.quad;
         ph8_ff.ang  <= ph.ang;
         ph8_ff.neg  <= ph.neg;
         ph8_ff.row  <= ph.row;
         ph8_ff.col  <= ph.col;
         i9_ff       <= i9_in;
         q9_ff       <= q9_in;
         row9_ff     <= ph8_ff.row;
         col9_ff     <= ph8_ff.col;
      end
   end

   assign rsp.valid    = v9_ff;
   assign rsp.sample_i = i9_ff;
   assign rsp.sample_q = q9_ff;
   assign rsp.grid_row = row9_ff;
   assign rsp.grid_col = col9_ff;

endmodule

`default_nettype wire

### rtl/nsss_sequence_generator.sv
// NB-IoT secondary sync sequence sample generator, nine-stage pipeline
// Usage:
//   csr_ch  register writes: index 0 is the cell id, index 1 the frame number;
//           always ready; written only while no item is in flight, a rule the block does not enforce
//   req_ch  one item carries a sample index n (0..131; 132 and above wrap by 132)
//   rsp_ch  one item per request: I/Q in signed fixed point with FRAC_BITS
//           fraction bits, plus the row and column of the 12x11 grid
// Throughput: one item per clock unless rsp_ch stalls; items fully independent.
// Pipeline: an accepted request reaches rsp_ch through nine register stages:
//   index reduction, root table, root multiply, reciprocal quotient,
//   remainder, phase wrap, quadrant split, sine/cosine rom read and the
//   output register.
// Stall: when rsp_ch holds a result that is not taken, the whole pipeline
//   freezes and req_ch drops ready in the same cycle; nothing is lost or repeated.
// Reset: clears all valid bits and sets cell id and frame number to zero.
`default_nettype none

module nsss_sequence_generator #(
   parameter int FRAC_BITS = nsss_pkg::FRAC_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   nsss_csr_if.sink     csr_ch,
   nsss_req_if.sink     req_ch,
   nsss_rsp_if.source   rsp_ch
);
   import nsss_pkg::*;

   cfg_type   cfg;
   phase_type ph;
   logic      adv;

   nsss_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   nsss_phase u_phase (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .cfg   (cfg),
      .req   (req_ch),
      .ph    (ph)
   );

   nsss_trig #(
      .FRAC_BITS (FRAC_BITS)
   ) u_trig (
      .clock (clock),
      .reset (reset),
      .ph    (ph),
      .adv   (adv),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

### tb/sv/nsss_sequence_checker.sv
`timescale 1ns / 100ps
// checker of the nsss sequence generator: predicts each sample and compares the responses
module nsss_sequence_checker #(
   parameter int FRAC_BITS = 14
) (
   input  wire  clock,
   input  wire  reset,
   nsss_csr_if  csr_mon,
   nsss_req_if  req_mon,
   nsss_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count,
   output int   checked_count
);
   import nsss_pkg::*;

   localparam logic [63:0] PI_FIX   = 64'hC90FDAA22168C234;
   localparam logic [63:0] ONE_FIX  = 64'd1 << 62;
   localparam logic [63:0] ANG_STEP = PI_FIX / 64'd524;
   localparam logic [63:0] ANG_REM  = PI_FIX % 64'd524;
   localparam int QTR_STEPS  = 262;
   localparam int TURN_STEPS = 1048;
   localparam int ERR_SHOWN  = 20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] i;
      logic signed [SAMPLE_W-1:0] q;
      logic [GRID_W-1:0]          row;
      logic [GRID_W-1:0]          col;
   } nsss_sample_type;

   typedef struct {
      logic [IDX_W-1:0] index;
      nsss_sample_type  sample;
   } pending_sample_type;

   logic [31:0]           cos_round [QTR_STEPS];
   logic [31:0]           sin_round [QTR_STEPS];
   logic [CELL_W-1:0]     cell_id_cfg;
   logic [CSR_DATA_W-1:0] frame_cfg;
   pending_sample_type    sample_fifo [$];

   // (a*b) >> 62 in q2.62, truncated
   function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[125:62];
   endfunction

   // first-quadrant sine and cosine of r*pi/524, taylor terms up to x^27
   function automatic void taylor_sincos(input int unsigned r, output logic [63:0] s_sum,
                                         output logic [63:0] c_sum);
      logic [63:0] x, x2, s_term, c_term;
      x      = 64'(r) * ANG_STEP + (64'(r) * ANG_REM) / 64'd524;
      x2     = fix_mul(x, x);
      s_term = x;
      c_term = ONE_FIX;
      s_sum  = x;
      c_sum  = ONE_FIX;
      for (int k = 1; k <= 13; k++) begin
         s_term = fix_mul(s_term, x2) / 64'(2 * k * (2 * k + 1));
         c_term = fix_mul(c_term, x2) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            s_sum = s_sum - s_term;
            c_sum = c_sum - c_term;
         end else begin
            s_sum = s_sum + s_term;
            c_sum = c_sum + c_term;
         end
      end
   endfunction

   function automatic logic [31:0] round_mag(input logic [63:0] v);
      logic [63:0] t;
      t = (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      return t[31:0];
   endfunction

   // sign applied after rounding, low bits kept
   function automatic logic signed [SAMPLE_W-1:0] signed_sample(input logic [31:0] mag,
                                                               input logic neg);
      logic [31:0] v;
      v = neg ? (32'd0 - mag) : mag;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic nsss_sample_type predict_sample(input logic [CELL_W-1:0] cell_val,
                                                      input logic [CSR_DATA_W-1:0] frame,
                                                      input logic [IDX_W-1:0] idx);
      int unsigned     n, cid, root, sign_row, np, shift, phase, k, r;
      logic [1:0]      quad;
      logic [6:0]      row_mask;
      logic            c_neg, s_neg, flip;
      logic [31:0]     c_mag, s_mag;
      nsss_sample_type res;
      n = idx;
      if (n >= 132) n = n - 132;
      cid      = cell_val;
      root     = cid % 126 + 3;
      sign_row = cid / 126;
      if (sign_row > 3) sign_row = 3;
      np    = n % 131;
      shift = frame % 32;
      phase = (4 * root * np * (np + 1) + 131 * n * shift) % TURN_STEPS;
      k     = (TURN_STEPS - phase) % TURN_STEPS;
      quad  = 2'(k / QTR_STEPS);
      r     = k % QTR_STEPS;
      case (quad)
         QUAD_0: begin
            c_mag = cos_round[r]; c_neg = 1'b0; s_mag = sin_round[r]; s_neg = 1'b0;
         end
         QUAD_1: begin
            c_mag = sin_round[r]; c_neg = 1'b1; s_mag = cos_round[r]; s_neg = 1'b0;
         end
         QUAD_2: begin
            c_mag = cos_round[r]; c_neg = 1'b1; s_mag = sin_round[r]; s_neg = 1'b1;
         end
         default: begin
            c_mag = sin_round[r]; c_neg = 1'b0; s_mag = cos_round[r]; s_neg = 1'b1;
         end
      endcase
      case (sign_row)
         0:       row_mask = 7'd0;
         1:       row_mask = 7'd31;
         2:       row_mask = 7'd63;
         default: row_mask = 7'd127;
      endcase
      // hadamard-type sign: parity of the masked low index bits
      flip    = ^(7'(n % 128) & row_mask);
      res.i   = signed_sample(c_mag, c_neg ^ flip);
      res.q   = signed_sample(s_mag, s_neg ^ flip);
      res.row = GRID_W'(n % 12);
      res.col = GRID_W'(n / 12);
      return res;
   endfunction

   initial begin
      logic [63:0] s_fix, c_fix;
      for (int r = 0; r < QTR_STEPS; r++) begin
         taylor_sincos(r, s_fix, c_fix);
         sin_round[r] = round_mag(s_fix);
         cos_round[r] = round_mag(c_fix);
      end
   end

   always @(posedge clock) begin
      pending_sample_type entry;
      pending_sample_type head;
      nsss_sample_type    got;
      if (reset) begin
         cell_id_cfg   = '0;
         frame_cfg     = '0;
         error_count   = 0;
         checked_count = 0;
         sample_fifo.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_CELL_ID) cell_id_cfg = csr_mon.data[CELL_W-1:0];
            else if (csr_mon.index == CSR_FRAME) frame_cfg = csr_mon.data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.sample_i, rsp_mon.sample_q, rsp_mon.grid_row, rsp_mon.grid_col};
            if (sample_fifo.size() == 0) begin
               error_count++;
               if (error_count <= ERR_SHOWN)
                  $display("%0t: unexpected item i=%0d q=%0d row=%0d col=%0d", $time,
                           got.i, got.q, got.row, got.col);
            end else begin
               head = sample_fifo.pop_front();
               checked_count++;
               if (got !== head.sample) begin
                  error_count++;
                  if (error_count <= ERR_SHOWN)
                     $display({"%0t: index %0d expected i=%0d q=%0d row=%0d col=%0d,",
                               " got i=%0d q=%0d row=%0d col=%0d"}, $time, head.index,
                              head.sample.i, head.sample.q, head.sample.row, head.sample.col,
                              got.i, got.q, got.row, got.col);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            entry.index  = req_mon.sample_index;
            entry.sample = predict_sample(cell_id_cfg, frame_cfg, req_mon.sample_index);
            sample_fifo.push_back(entry);
         end
      end
      pending_count = sample_fifo.size();
   end

endmodule

### tb/sv/tb_nsss_sequence_generator.sv
`timescale 1ns / 100ps
// testbench top of the nsss sequence generator: stimulus, idling and verdict
module tb_nsss_sequence_generator;
   import nsss_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int ITEM_TARGET  = 1100;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 16;

   logic clock = 1'b0;
   logic reset;

   nsss_csr_if csr_ch ();
   nsss_req_if req_ch ();
   nsss_rsp_if rsp_ch ();

   int error_count;
   int pending_count;
   int checked_count;
   int cycle_count = 0;

   bit gap_mode;
   bit stall_mode;
   int rsp_hold = 0;

   logic [IDX_W-1:0] reset_cfg_idx [12] = '{8'd0, 8'd1, 8'd2, 8'd11, 8'd12, 8'd127, 8'd128,
                                            8'd130, 8'd131, 8'd132, 8'd143, 8'd255};
   logic [IDX_W-1:0] corner_cfg_idx [8] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'd128, 8'd131,
                                            8'd200, 8'd254};
   logic [IDX_W-1:0] idx_corners [4] = '{8'd0, 8'd131, 8'd132, 8'd255};
   logic [CELL_W-1:0] cell_corners [10] = '{9'd0, 9'd125, 9'd126, 9'd251, 9'd252, 9'd377,
                                            9'd378, 9'd503, 9'd504, 9'd511};
   logic [CSR_DATA_W-1:0] frame_corners [6] = '{10'd0, 10'd1, 10'd31, 10'd32, 10'd993,
                                                10'd1023};

   always #2 clock = ~clock;

   nsss_sequence_generator #(
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nsss_sequence_checker #(
      .FRAC_BITS(FRAC)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_mon       (csr_ch),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: runs of ready and stalls, mostly short stalls with a few long ones
   always @(negedge clock) begin
      if (!stall_mode) begin
         rsp_ch.ready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (rsp_ch.ready) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_hold = $urandom_range(0, 11);
      end
   end

   task automatic send_index(input logic [IDX_W-1:0] idx);
      int gap;
      int roll;
      gap  = 0;
      roll = $urandom_range(0, 99);
      if (gap_mode && roll >= 55) gap = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // sender holds off until every outstanding sample has come back
   task automatic drain_samples();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int settings;
      int phase_len;
      int roll;
      logic [CELL_W-1:0]     cell_val;
      logic [CSR_DATA_W-1:0] frame;
      logic [IDX_W-1:0]      idx;
      sent     = 0;
      settings = 1;
      reset               = 1'b1;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_CELL_ID;
      csr_ch.data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.sample_index = '0;
      rsp_ch.ready        = 1'b0;
      gap_mode            = 1'b1;
      stall_mode          = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: no sign flip, no cyclic shift, index wrap past 131
      foreach (reset_cfg_idx[j]) begin
         send_index(reset_cfg_idx[j]);
         sent++;
      end
      // cell id past 503 saturates the sign row, top data bit is ignored
      drain_samples();
      write_csr(CSR_CELL_ID, 10'h3FF);
      write_csr(CSR_FRAME, 10'd1023);
      settings++;
      foreach (corner_cfg_idx[j]) begin
         send_index(corner_cfg_idx[j]);
         sent++;
      end

      while (sent < ITEM_TARGET) begin
         drain_samples();
         cell_val = ($urandom_range(0, 3) == 0) ? cell_corners[$urandom_range(0, 9)]
                                                 : CELL_W'($urandom_range(0, 511));
         frame    = ($urandom_range(0, 3) == 0) ? frame_corners[$urandom_range(0, 5)]
                                                 : CSR_DATA_W'($urandom_range(0, 1023));
         roll  = $urandom_range(0, 5);
         if (roll != 5) write_csr(CSR_CELL_ID, {1'($urandom_range(0, 1)), cell_val});
         if (roll != 4) write_csr(CSR_FRAME, frame);
         settings++;
         gap_mode   = ($urandom_range(0, 3) != 0);
         stall_mode = ($urandom_range(0, 3) != 0);
         phase_len  = $urandom_range(30, 90);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) == 0) drain_samples();
            roll = $urandom_range(0, 99);
            if (roll < 85) idx = IDX_W'($urandom_range(0, 131));
            else if (roll < 95) idx = IDX_W'($urandom_range(132, 255));
            else idx = idx_corners[$urandom_range(0, 3)];
            send_index(idx);
            sent++;
         end
      end

      drain_samples();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("checked %0d samples from %0d requests under %0d register settings",
               checked_count, sent, settings);
      $display("covered index wrap, cell ids past 503, all frame shifts and stalls on both sides");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/nsss_pkg.sv
rtl/nsss_if.sv
rtl/nsss_csr.sv
rtl/nsss_phase.sv
rtl/nsss_trig.sv
rtl/nsss_sequence_generator.sv
tb/sv/nsss_sequence_checker.sv
tb/sv/tb_nsss_sequence_generator.sv
